@@ hdl/hcspc_pkg.sv @@
`default_nettype none

package hcspc_pkg;

  // drive clamp and fixed-point position of the speed error product
  localparam int PWM_FULL_SCALE = 512;
  localparam int FRACTION_BITS  = 16;

  localparam int DUTY_W    = 10;
  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN            = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_PER_COUNT = 2'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd5000;
  localparam logic [DATA_W-1:0] SPC_RESET  = 32'd65536;

  // hall code -> electrical sector; invalid codes 0 and 7 map to sector 0
  function automatic logic [2:0] sector_of(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'd1:    s = 3'd0;
      3'd3:    s = 3'd1;
      3'd2:    s = 3'd2;
      3'd6:    s = 3'd3;
      3'd4:    s = 3'd4;
      3'd5:    s = 3'd5;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hdl/hcspc_mul.sv @@
`default_nettype none

// Unsigned shift-add multiplier, two multiplier bits per cycle.
// Finishes early once the remaining multiplier bits are all zero.
module hcspc_mul (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [hcspc_pkg::MUL_W-1:0]     mcand,
  input  wire logic [hcspc_pkg::MUL_W-1:0]     mplier,
  output logic                                 busy,
  output logic      [2*hcspc_pkg::MUL_W-1:0]   product
);

  localparam int PW = 2 * hcspc_pkg::MUL_W;

  logic [PW-1:0]                 mcand_r;
  logic [PW-1:0]                 mcand3_r;
  logic [PW-1:0]                 acc_r;
  logic [hcspc_pkg::MUL_W-1:0]   mplier_r;
  logic [PW-1:0]                 pp;

  always_comb begin
    case (mplier_r[1:0])
      2'd0:    pp = '0;
      2'd1:    pp = mcand_r;
      2'd2:    pp = {mcand_r[PW-2:0], 1'b0};
      2'd3:    pp = mcand3_r;
      default: pp = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mplier_r <= '0;
    end else if (start) begin
      mplier_r <= mplier;
    end else if (busy) begin
      mplier_r <= mplier_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= PW'(mcand);
      mcand3_r <= PW'(mcand) + (PW'(mcand) << 1);
      acc_r    <= '0;
    end else if (busy) begin
      acc_r    <= acc_r + pp;
      mcand_r  <= mcand_r << 2;
      mcand3_r <= mcand3_r << 2;
    end
  end

  assign busy    = (mplier_r != '0);
  assign product = acc_r;

endmodule

`default_nettype wire

@@ hdl/hall_counter_speed_p_controller.sv @@
// Hall step counter with a proportional speed loop.
// Input channel (in_valid / in_stall): in_func = 0 is a hall edge carrying
// in_hall_code; in_func = 1 is a control tick carrying in_target_speed.
// Every request yields one result on the output channel (out_valid /
// out_stall): duty, direction, position count and last measured speed.
// Config (cfg_valid / cfg_ready, always ready): index 0 = gain,
// index 1 = speed per count (Q16.16); other indexes are dropped.
// A hall edge goes straight to ST_LOAD; out_valid rises once it is loaded.
// A tick runs two products through one shift-add multiplier retiring two
// multiplier bits a cycle, count diff x speed per count and then gain x
// error, each ending early past the top set bit of speed per count or of
// gain; the states run SPD_MUL, SPD_SAT, ERR, GAIN_MUL, DRIVE, then LOAD.
// One request is in flight at a time; in_stall is high until its result
// is loaded into the output register, and only then is a new request taken.
// The next request can be taken while that result still waits on out_stall.
// Reset (rst_n, synchronous): count, speed, duty cleared, direction forward,
// gain 5000, speed per count 1.0. A stalled result holds its value.
`default_nettype none

module hall_counter_speed_p_controller (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_func,
  input  wire logic [2:0]                           in_hall_code,
  input  wire logic signed [hcspc_pkg::DATA_W-1:0]  in_target_speed,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic      [hcspc_pkg::DUTY_W-1:0]         out_pwm_duty,
  output logic                                      out_direction,
  output logic signed [hcspc_pkg::DATA_W-1:0]       out_position_count,
  output logic signed [hcspc_pkg::DATA_W-1:0]       out_measured_speed,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [hcspc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hcspc_pkg::DATA_W-1:0]         cfg_wdata
);

  localparam int DW = hcspc_pkg::DATA_W;
  localparam int PW = 2 * hcspc_pkg::MUL_W;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SPD_MUL  = 3'd1;
  localparam logic [2:0] ST_SPD_SAT  = 3'd2;
  localparam logic [2:0] ST_ERR      = 3'd3;
  localparam logic [2:0] ST_GAIN_MUL = 3'd4;
  localparam logic [2:0] ST_DRIVE    = 3'd5;
  localparam logic [2:0] ST_LOAD     = 3'd6;

  logic [2:0]                      state_r;
  logic [hcspc_pkg::GAIN_W-1:0]    gain_r;
  logic [DW-1:0]                   spc_r;
  logic [2:0]                      last_sector_r;
  logic [DW-1:0]                   step_count_r;
  logic [DW-1:0]                   tick_count_r;
  logic [DW-1:0]                   speed_r;
  logic [hcspc_pkg::DUTY_W-1:0]    duty_r;
  logic                            dir_r;
  logic [DW-1:0]                   target_r;
  logic                            neg_r;

  logic                            out_valid_r;
  logic [hcspc_pkg::DUTY_W-1:0]    out_duty_r;
  logic                            out_dir_r;
  logic [DW-1:0]                   out_pos_r;
  logic [DW-1:0]                   out_spd_r;

  logic                            in_acc;
  logic                            load_ok;
  logic [2:0]                      sector_now;
  logic                            step_up;
  logic [DW-1:0]                   diff;
  logic [DW-1:0]                   diff_mag;
  logic [DW:0]                     err;
  logic [DW:0]                     err_mag;
  logic [DW-1:0]                   spd_sat;
  logic [PW-1:0]                   mag_full;
  logic [hcspc_pkg::DUTY_W-1:0]    duty_clamp;

  logic                            mul_start;
  logic [hcspc_pkg::MUL_W-1:0]     mul_a;
  logic [hcspc_pkg::MUL_W-1:0]     mul_b;
  logic                            mul_busy;
  logic [PW-1:0]                   mul_p;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_ok   = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // hall stepping: forward across the 5 -> 0 wrap, reverse across 0 -> 5
  always_comb begin
    sector_now = hcspc_pkg::sector_of(in_hall_code);
    if (last_sector_r == 3'd5 && sector_now == 3'd0) begin
      step_up = 1'b1;
    end else if (last_sector_r == 3'd0 && sector_now == 3'd5) begin
      step_up = 1'b0;
    end else begin
      step_up = (sector_now > last_sector_r);
    end
  end

  assign diff     = step_count_r - tick_count_r;
  assign diff_mag = diff[DW-1] ? (~diff + 1'b1) : diff;

  // saturate the signed speed to 32 bits
  always_comb begin
    if (!neg_r) begin
      spd_sat = (mul_p > PW'(64'h0000_0000_7FFF_FFFF)) ? 32'h7FFF_FFFF : mul_p[DW-1:0];
    end else if (mul_p > PW'(64'h0000_0000_8000_0000)) begin
      spd_sat = 32'h8000_0000;
    end else begin
      spd_sat = ~mul_p[DW-1:0] + 1'b1;
    end
  end

  assign err     = {target_r[DW-1], target_r} - {speed_r[DW-1], speed_r};
  assign err_mag = err[DW] ? (~err + 1'b1) : err;

  assign mag_full   = mul_p >> hcspc_pkg::FRACTION_BITS;
  assign duty_clamp = (mag_full > PW'(hcspc_pkg::PWM_FULL_SCALE))
                      ? hcspc_pkg::DUTY_W'(hcspc_pkg::PWM_FULL_SCALE)
                      : mag_full[hcspc_pkg::DUTY_W-1:0];

  always_comb begin
    mul_start = 1'b0;
    mul_a     = diff_mag;
    mul_b     = spc_r;
    if (state_r == ST_IDLE) begin
      mul_start = in_acc && in_func;
    end else if (state_r == ST_ERR) begin
      mul_start = 1'b1;
      mul_a     = err_mag[DW-1:0];
      mul_b     = hcspc_pkg::MUL_W'(gain_r);
    end
  end

  hcspc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .busy    (mul_busy),
    .product (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= hcspc_pkg::GAIN_RESET;
      spc_r  <= hcspc_pkg::SPC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == hcspc_pkg::CFG_GAIN) begin
        gain_r <= cfg_wdata[hcspc_pkg::GAIN_W-1:0];
      end else if (cfg_index == hcspc_pkg::CFG_SPEED_PER_COUNT) begin
        spc_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      last_sector_r <= '0;
      step_count_r  <= '0;
      tick_count_r  <= '0;
      speed_r       <= '0;
      duty_r        <= '0;
      dir_r         <= 1'b1;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_func) begin
            tick_count_r <= step_count_r;
            state_r      <= ST_SPD_MUL;
          end else if (in_acc) begin
            step_count_r  <= step_up ? step_count_r + 1'b1 : step_count_r - 1'b1;
            last_sector_r <= sector_now;
            state_r       <= ST_LOAD;
          end
        end
        ST_SPD_MUL: begin
          if (!mul_busy) begin
            state_r <= ST_SPD_SAT;
          end
        end
        ST_SPD_SAT: begin
          speed_r <= spd_sat;
          state_r <= ST_ERR;
        end
        ST_ERR: begin
          state_r <= ST_GAIN_MUL;
        end
        ST_GAIN_MUL: begin
          if (!mul_busy) begin
            state_r <= ST_DRIVE;
          end
        end
        ST_DRIVE: begin
          // a product that truncates to zero still reports reverse
          dir_r   <= !(neg_r && (mul_p != '0));
          duty_r  <= duty_clamp;
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          if (load_ok) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // payload side: target latch and the sign of the current product
  always_ff @(posedge clk) begin
    if (in_acc) begin
      target_r <= in_target_speed;
      neg_r    <= diff[DW-1];
    end else if (state_r == ST_ERR) begin
      neg_r <= err[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_LOAD && load_ok) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && load_ok) begin
      out_duty_r <= duty_r;
      out_dir_r  <= dir_r;
      out_pos_r  <= step_count_r;
      out_spd_r  <= speed_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pwm_duty       = out_duty_r;
  assign out_direction      = out_dir_r;
  assign out_position_count = out_pos_r;
  assign out_measured_speed = out_spd_r;

`ifndef SYNTHESIS
  a_duty_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pwm_duty <= hcspc_pkg::DUTY_W'(hcspc_pkg::PWM_FULL_SCALE)))
    else $error("duty above full scale");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("sequencer idle right after a request");

  a_mul_in_wait_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_busy |-> (state_r == ST_SPD_MUL || state_r == ST_GAIN_MUL))
    else $error("multiplier running outside a wait state");

  a_hall_keeps_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_func) |=> ($stable(speed_r) && $stable(duty_r) && $stable(tick_count_r)))
    else $error("hall edge disturbed speed loop state");
`endif

endmodule

`default_nettype wire

@@ test/hcspc_tb_pkg.sv @@
`timescale 1ns / 100ps

package hcspc_tb_pkg;

  // request kinds on the input channel
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

endpackage

@@ test/hcspc_checker.sv @@
`timescale 1ns / 100ps

module hcspc_checker
  import hcspc_pkg::*, hcspc_tb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_func,
  input  logic [2:0]               in_hall_code,
  input  logic signed [DATA_W-1:0] in_target_speed,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [DUTY_W-1:0]        out_pwm_duty,
  input  logic                     out_direction,
  input  logic signed [DATA_W-1:0] out_position_count,
  input  logic signed [DATA_W-1:0] out_measured_speed,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  output int                       fail_count,
  output int                       pending_count
);

  typedef struct {
    logic [DUTY_W-1:0] duty;
    logic              dir;
    logic [DATA_W-1:0] pos;
    logic [DATA_W-1:0] spd;
  } drive_report_t;

  localparam logic [2:0] SECTOR_OF_CODE [0:7] =
    '{3'd0, 3'd0, 3'd2, 3'd1, 3'd4, 3'd5, 3'd3, 3'd0};
  localparam longint SPEED_MAX = 64'sd2147483647;
  localparam longint SPEED_MIN = -64'sd2147483648;

  logic [GAIN_W-1:0] gain_q;
  logic [DATA_W-1:0] spc_q;
  logic [2:0]        sector_q;
  logic [DATA_W-1:0] count_q;
  logic [DATA_W-1:0] snap_q;
  logic [DATA_W-1:0] speed_q;
  logic [DUTY_W-1:0] duty_q;
  logic              dir_q;

  drive_report_t expected_reports [$];

  function automatic void advance_position(input logic [2:0] code);
    logic [2:0] now;
    logic       up;
    now = SECTOR_OF_CODE[code];
    // wrap between the last and first sector; a repeated sector counts down
    if (sector_q == 3'd5 && now == 3'd0) up = 1'b1;
    else if (sector_q == 3'd0 && now == 3'd5) up = 1'b0;
    else up = now > sector_q;
    count_q = up ? count_q + 1'b1 : count_q - 1'b1;
    sector_q = now;
  endfunction

  function automatic void update_drive(input logic signed [DATA_W-1:0] target);
    logic signed [DATA_W-1:0] delta;
    longint                   raw;
    longint                   err;
    longint                   prod;
    longint unsigned          mag;
    delta = count_q - snap_q;
    raw = longint'(delta) * longint'({32'd0, spc_q});
    if (raw > SPEED_MAX) raw = SPEED_MAX;
    if (raw < SPEED_MIN) raw = SPEED_MIN;
    speed_q = raw[DATA_W-1:0];
    snap_q = count_q;
    err = longint'(target) - raw;
    prod = longint'({48'd0, gain_q}) * err;
    // direction follows the sign before the shift
    if (prod < 0) begin
      dir_q = 1'b0;
      mag = -prod;
    end else begin
      dir_q = 1'b1;
      mag = prod;
    end
    mag = mag >> FRACTION_BITS;
    if (mag > PWM_FULL_SCALE) mag = 64'(PWM_FULL_SCALE);
    duty_q = mag[DUTY_W-1:0];
  endfunction

  always @(posedge clk) begin
    drive_report_t want;
    if (!rst_n) begin
      gain_q = GAIN_RESET;
      spc_q = SPC_RESET;
      sector_q = 3'd0;
      count_q = '0;
      snap_q = '0;
      speed_q = '0;
      duty_q = '0;
      dir_q = 1'b1;
      expected_reports.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GAIN:            gain_q = cfg_wdata[GAIN_W-1:0];
          CFG_SPEED_PER_COUNT: spc_q = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result with no request outstanding: duty %0d, position %0d",
                 out_pwm_duty, out_position_count);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_pwm_duty !== want.duty) begin
            $error("pwm_duty: expected %0d, got %0d", want.duty, out_pwm_duty);
            fail_count++;
          end
          if (out_direction !== want.dir) begin
            $error("direction: expected %0d, got %0d", want.dir, out_direction);
            fail_count++;
          end
          if (out_position_count !== want.pos) begin
            $error("position_count: expected %0d, got %0d",
                   $signed(want.pos), out_position_count);
            fail_count++;
          end
          if (out_measured_speed !== want.spd) begin
            $error("measured_speed: expected %0d, got %0d",
                   $signed(want.spd), out_measured_speed);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_TICK) update_drive(in_target_speed);
        else advance_position(in_hall_code);
        want.duty = duty_q;
        want.dir = dir_q;
        want.pos = count_q;
        want.spd = speed_q;
        expected_reports.push_back(want);
      end
    end
    pending_count = expected_reports.size();
  end

endmodule

@@ test/tb_hall_counter_speed_p_controller.sv @@
`timescale 1ns / 100ps

module tb_hall_counter_speed_p_controller;
  import hcspc_pkg::*;
  import hcspc_tb_pkg::*;

  // indexes the block has no register for
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [2:0] CODE_OF_SECTOR [0:5] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 210;

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_stall;
  logic                     in_func;
  logic [2:0]               in_hall_code;
  logic signed [DATA_W-1:0] in_target_speed;
  logic                     out_valid;
  logic                     out_stall;
  logic [DUTY_W-1:0]        out_pwm_duty;
  logic                     out_direction;
  logic signed [DATA_W-1:0] out_position_count;
  logic signed [DATA_W-1:0] out_measured_speed;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_wdata;

  int fail_count;
  int pending_count;

  bit                gaps_on;
  bit                long_hold_req;
  bit                run_fwd;
  int                cur_sector;
  logic [DATA_W-1:0] cur_spc;
  logic [GAIN_W-1:0] phase_gain [PHASES];
  logic [DATA_W-1:0] phase_spc  [PHASES];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hall_counter_speed_p_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_hall_code       (in_hall_code),
    .in_target_speed    (in_target_speed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pwm_duty       (out_pwm_duty),
    .out_direction      (out_direction),
    .out_position_count (out_position_count),
    .out_measured_speed (out_measured_speed),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  hcspc_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_hall_code       (in_hall_code),
    .in_target_speed    (in_target_speed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pwm_duty       (out_pwm_duty),
    .out_direction      (out_direction),
    .out_position_count (out_position_count),
    .out_measured_speed (out_measured_speed),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_target();
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // near a plausible measured speed so the duty lands below the clamp
        k = $urandom_range(0, 8) - 4;
        return 32'(longint'(k) * longint'({32'd0, cur_spc}))
               + 32'($urandom_range(0, 8191)) - 32'd4096;
      end
      3, 4:    return 32'($urandom_range(0, 4095)) - 32'd2048;
      5, 6, 7: return $urandom;
      8:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue_request(input logic func, input logic [2:0] code,
                               input logic [DATA_W-1:0] target);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_hall_code <= code;
    in_target_speed <= target;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_edge(input logic [2:0] code);
    issue_request(FUNC_EDGE, code, $urandom);
  endtask

  task automatic send_tick(input logic [DATA_W-1:0] target);
    issue_request(FUNC_TICK, 3'($urandom_range(0, 7)), target);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == CFG_SPEED_PER_COUNT) cur_spc = data;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  // mostly clean rotation runs, some ticks, some arbitrary codes
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 68) begin
      if ($urandom_range(0, 19) == 0) run_fwd = !run_fwd;
      if (run_fwd) cur_sector = (cur_sector == 5) ? 0 : cur_sector + 1;
      else cur_sector = (cur_sector == 0) ? 5 : cur_sector - 1;
      send_edge(CODE_OF_SECTOR[cur_sector]);
    end else if (r < 88) begin
      send_tick(pick_target());
    end else begin
      send_edge(3'($urandom_range(0, 7)));
    end
  endtask

  initial begin : receiver
    int stall_left;
    int mode_left;
    int r;
    bit quiet;
    out_stall = 1'b0;
    stall_left = 0;
    mode_left = 0;
    quiet = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          quiet = ($urandom_range(0, 3) == 0);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else if (quiet) begin
          out_stall <= 1'b0;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 65) begin
            out_stall <= 1'b0;
          end else begin
            out_stall <= 1'b1;
            stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
          end
        end
      end
    end
  end

  initial begin : stimulus
    in_valid = 1'b0;
    in_func = FUNC_EDGE;
    in_hall_code = 3'd0;
    in_target_speed = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GAIN;
    cfg_wdata = '0;
    rst_n = 1'b0;
    gaps_on = 1'b0;
    long_hold_req = 1'b0;
    run_fwd = 1'b1;
    cur_sector = 0;
    cur_spc = SPC_RESET;
    phase_gain = '{16'hFFFF, 16'd0, GAIN_RESET, 16'd1, 16'($urandom), 16'($urandom),
                   16'd200, 16'hFFFF};
    phase_spc = '{32'hFFFF_FFFF, 32'd0, SPC_RESET, 32'd1, 32'($urandom_range(1, 262144)),
                  $urandom, 32'd300, 32'd65536};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset settings
    send_tick(32'd0);
    send_edge(3'd1);                 // same sector steps down
    send_edge(3'd3);
    send_edge(3'd2);
    send_edge(3'd6);
    send_edge(3'd4);
    send_edge(3'd5);
    send_edge(3'd1);                 // last sector to first: up
    send_edge(3'd5);                 // first to last: down
    send_edge(3'd7);                 // invalid codes read as sector 0
    send_edge(3'd0);
    send_tick(32'h7FFF_FFFF);
    send_tick(32'h8000_0000);
    send_tick(32'hFFFF_FFFF);        // tiny negative product: zero duty, reverse
    send_tick(32'd0);
    drain();
    write_reg(CFG_SPEED_PER_COUNT, 32'hFFFF_FFFF);
    send_edge(3'd3);
    send_edge(3'd2);
    send_tick(32'd0);                // speed saturates high
    send_edge(3'd3);
    send_edge(3'd1);
    send_edge(3'd5);
    send_tick(32'd0);                // speed saturates low
    cur_sector = 5;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(CFG_GAIN, {16'd0, phase_gain[p]});
      write_reg(CFG_SPEED_PER_COUNT, phase_spc[p]);
      if (p == 3) begin
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
      end
      if (p == 2) begin
        // output held off while requests keep coming, so the input backs up
        long_hold_req = 1'b1;
        gaps_on = 1'b0;
        repeat (12) random_item();
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        random_item();
      end
    end

    drain();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ hall_counter_speed_p_controller.f @@
hdl/hcspc_pkg.sv
hdl/hcspc_mul.sv
hdl/hall_counter_speed_p_controller.sv
test/hcspc_tb_pkg.sv
test/hcspc_checker.sv
test/tb_hall_counter_speed_p_controller.sv
